/* sv/dfd_pkg.sv */
// package for the escaped frame deframer with additive checksum
// holds the framing codes, data width and the shared arithmetic unit request type
// no dependencies
package dfd_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned DefDepth  = 64;
  localparam int unsigned HeaderLen = 2;

  // framing codes
  localparam logic [DataW-1:0] EscByte   = 8'd70;
  localparam logic [DataW-1:0] CodeStart = 8'd0;
  localparam logic [DataW-1:0] CodeEnd   = 8'd255;

  typedef enum logic {
    AluAdd,
    AluSub
  } alu_op_e;

  // one request to the shared add/subtract/compare unit
  typedef struct packed {
    alu_op_e          op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

endpackage

/* sv/dfd_if.sv */
// valid/ready stream interfaces for the deframer: raw receive bytes in, payload beats out
// depends on dfd_pkg for the data width
interface dfd_rx_if;
  logic                     valid;
  logic                     ready;
  logic [dfd_pkg::DataW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfd_out_if;
  logic                     valid;
  logic                     ready;
  logic [dfd_pkg::DataW-1:0] payload_byte;
  logic                     last_of_frame;
  logic                     empty_frame;

  modport source (output valid, output payload_byte, output last_of_frame,
                  output empty_frame, input ready);
  modport sink   (input valid, input payload_byte, input last_of_frame,
                  input empty_frame, output ready);
endinterface

/* sv/dfd_alu.sv */
// shared 8-bit add/subtract unit with an equality compare
// depends on dfd_pkg for the request type
module dfd_alu (
  input  dfd_pkg::alu_req_t          req_i,
  output logic [dfd_pkg::DataW-1:0]  res_o,
  output logic                       eq_o
);
  import dfd_pkg::*;

  // modulo-256 add or subtract
  always_comb begin
    case (req_i.op)
      AluAdd:  res_o = req_i.a + req_i.b;
      AluSub:  res_o = req_i.a - req_i.b;
      default: res_o = req_i.a;
    endcase
  end

  assign eq_o = (req_i.a == req_i.b);

endmodule

/* sv/dfd_store.sv */
// frame store: one write port, one read port with registered read data
// depends on dfd_pkg for the data width
module dfd_store #(
  parameter int unsigned DEPTH = dfd_pkg::DefDepth
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [dfd_pkg::DataW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [dfd_pkg::DataW-1:0]  rdata_o
);
  import dfd_pkg::*;

  logic [DataW-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/escaped_frame_deframer_checksum.sv */
// top level of the escaped frame deframer with additive checksum
// depends on dfd_pkg, dfd_if, dfd_alu and dfd_store
//
// Receives raw bytes one beat at a time, strips the escape framing (escape 70 followed by
// 0 = start, 70 = literal 70, 255 = end, anything else dropped), stores frame bytes and keeps
// a modulo-256 running sum. A frame is length byte, checksum byte, payload. At an end code
// the two header bytes are taken out of the sum and the frame is judged; a good frame is
// sent out one payload beat at a time with last_of_frame on the final beat, or as a single
// empty_frame beat when it has no payload. Bad frames produce nothing. Steps: a stored
// byte is decoded, then written to the store while the shared adder updates the sum; the
// escape and start/unknown codes are handled as they arrive; an end code leads to the two
// header reads, the two subtractions and the check, then each payload beat is read from
// the single registered read port of the store and loaded when the sink has room. The
// output register lets the next byte be accepted while the final beat still waits. The
// store needs no clearing after reset.
module escaped_frame_deframer_checksum #(
  parameter int unsigned DEPTH = dfd_pkg::DefDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dfd_rx_if.sink        rx_i,
  dfd_out_if.source     out_o
);
  import dfd_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SAdd    = 4'd1;
  localparam logic [3:0] SRd0    = 4'd2;
  localparam logic [3:0] SSub0   = 4'd3;
  localparam logic [3:0] SSub1   = 4'd4;
  localparam logic [3:0] SChk    = 4'd5;
  localparam logic [3:0] SEmpty  = 4'd6;
  localparam logic [3:0] SEmitRd = 4'd7;
  localparam logic [3:0] SEmitLd = 4'd8;

  logic [3:0]       state_q, state_d;
  logic             esc_q, esc_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [DataW-1:0] sum_q, sum_d;
  logic [DataW-1:0] byte_q, byte_d;
  logic [DataW-1:0] len_q, len_d;
  logic [DataW-1:0] chk_q, chk_d;
  logic [IW-1:0]    ptr_q, ptr_d;

  logic             out_vld_q, out_vld_d;
  logic [DataW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_empty_q, out_empty_d;

  logic             rx_fire;
  logic             slot_free;
  logic             out_load;
  logic             frame_good;
  logic             emit_last;

  alu_req_t         alu_req;
  logic [DataW-1:0] alu_res;
  logic             alu_eq;

  logic             mem_we;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  logic [DataW-1:0] mem_rdata;

  dfd_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res),
    .eq_o  (alu_eq)
  );

  dfd_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (byte_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rx_i.ready = (state_q == SIdle);
  assign rx_fire    = rx_i.valid && rx_i.ready;
  assign slot_free  = !out_vld_q || out_o.ready;

  // length byte must match payload count, checksum byte must match the reduced sum
  assign frame_good = ((9'(len_q) + 9'(HeaderLen)) == 9'(idx_q)) && alu_eq;
  assign emit_last  = (ptr_q == IW'(idx_q - IW'(1)));

  // sequencer
  always_comb begin
    state_d     = state_q;
    esc_d       = esc_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    byte_d      = byte_q;
    len_d       = len_q;
    chk_d       = chk_q;
    ptr_d       = ptr_q;
    alu_req.op  = AluAdd;
    alu_req.a   = sum_q;
    alu_req.b   = byte_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q;
    out_load    = 1'b0;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;

    case (state_q)
      SIdle: begin
        if (rx_fire) begin
          if (esc_q) begin
            esc_d = 1'b0;
            case (rx_i.rx_byte)
              CodeStart: begin
                idx_d = '0;
                sum_d = '0;
              end
              EscByte: begin
                byte_d  = rx_i.rx_byte;
                state_d = SAdd;
              end
              CodeEnd: begin
                state_d = SRd0;
              end
              default: ;
            endcase
          end else if (rx_i.rx_byte == EscByte) begin
            esc_d = 1'b1;
          end else begin
            byte_d  = rx_i.rx_byte;
            state_d = SAdd;
          end
        end
      end
      SAdd: begin
        mem_we = 1'b1;
        sum_d  = alu_res;
        if (idx_q != IW'(DEPTH - 1)) begin
          idx_d = idx_q + IW'(1);
        end
        state_d = SIdle;
      end
      SRd0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_d   = SSub0;
      end
      SSub0: begin
        alu_req.op = AluSub;
        alu_req.b  = mem_rdata;
        sum_d      = alu_res;
        len_d      = mem_rdata;
        mem_re     = 1'b1;
        mem_raddr  = IW'(1);
        state_d    = SSub1;
      end
      SSub1: begin
        alu_req.op = AluSub;
        alu_req.b  = mem_rdata;
        sum_d      = alu_res;
        chk_d      = mem_rdata;
        state_d    = SChk;
      end
      SChk: begin
        alu_req.b = chk_q;
        if (!frame_good) begin
          state_d = SIdle;
        end else if (len_q == '0) begin
          state_d = SEmpty;
        end else begin
          ptr_d   = IW'(HeaderLen);
          state_d = SEmitRd;
        end
      end
      SEmpty: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_byte_d  = '0;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
          state_d     = SIdle;
        end
      end
      SEmitRd: begin
        mem_re  = 1'b1;
        state_d = SEmitLd;
      end
      SEmitLd: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_byte_d  = mem_rdata;
          out_last_d  = emit_last;
          out_empty_d = 1'b0;
          if (emit_last) begin
            state_d = SIdle;
          end else begin
            ptr_d   = ptr_q + IW'(1);
            state_d = SEmitRd;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      esc_q     <= 1'b0;
      idx_q     <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      esc_q     <= esc_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    len_q       <= len_d;
    chk_q       <= chk_d;
    ptr_q       <= ptr_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.payload_byte  = out_byte_q;
  assign out_o.last_of_frame = out_last_q;
  assign out_o.empty_frame   = out_empty_q;

  // checks

  // a pending beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || out_o.ready))
    else $error("output beat overwritten while stalled");

  // the write index saturates at the last entry
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= DEPTH - 1)
    else $error("write index beyond the store");

  // the empty marker is a final beat with a zero byte
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_empty_q) |-> (out_last_q && (out_byte_q == '0)))
    else $error("malformed empty marker");

  // payload reads stay inside the stored frame
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmitRd) |-> ((32'(ptr_q) >= HeaderLen) && (ptr_q < idx_q)))
    else $error("payload read pointer out of frame");

  // an end of frame readout starts with the length byte read
  a_rd0_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && esc_q && (rx_i.rx_byte == CodeEnd)) |=> (state_q == SRd0))
    else $error("end code did not start the frame check");

endmodule

/* bench/escaped_frame_deframer_checksum_tb.sv */
// testbench for escaped_frame_deframer_checksum: directed and random byte streams with a
// scoreboard that decodes the escape framing and checks every payload beat in order
// depends on dfd_pkg, dfd_if and the deframer top level
`timescale 1ns / 100ps

module escaped_frame_deframer_checksum_tb;
  import dfd_pkg::*;

  localparam int Depth         = DefDepth;
  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 12;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 300;
  localparam int TimeoutCycles = 2_500_000;
  localparam int PhaseBytes    = 120;

  // escape code outside the known set, dropped by the block
  localparam logic [DataW-1:0] UnknownCode = 8'd3;
  // largest payload count the store can hold
  localparam int MaxCount = Depth - 1 - HeaderLen;

  // decodes the received stream and keeps the payload beats still to come
  class frame_scoreboard;
    typedef struct packed {
      logic [DataW-1:0] data;
      logic             last;
      logic             empty;
    } beat_t;

    beat_t            pending_beats[$];
    int               errors;
    bit               esc_seen;
    int unsigned      wr_idx;
    logic [DataW-1:0] sum;
    logic [DataW-1:0] store[Depth];

    function new();
      errors   = 0;
      esc_seen = 1'b0;
      wr_idx   = 0;
      sum      = '0;
      foreach (store[i]) store[i] = '0;
    endfunction

    // store at the write index, which sticks at the last entry
    function void put_byte(logic [DataW-1:0] b);
      store[wr_idx] = b;
      sum = sum + b;
      if (wr_idx < Depth - 1) wr_idx++;
    endfunction

    // end code: strip the header from the sum, judge the frame, queue its beats
    function void close_frame();
      int unsigned n;
      beat_t       bt;
      sum = sum - store[0] - store[1];
      if (wr_idx < HeaderLen) return;
      n = wr_idx - HeaderLen;
      if (int'(store[0]) != n || store[1] != sum) return;
      if (n == 0) begin
        bt = '{data: '0, last: 1'b1, empty: 1'b1};
        pending_beats.push_back(bt);
        return;
      end
      for (int unsigned i = 0; i < n; i++) begin
        bt = '{data: store[i + HeaderLen], last: (i + 1 == n), empty: 1'b0};
        pending_beats.push_back(bt);
      end
    endfunction

    // one accepted input beat
    function void note_rx(logic [DataW-1:0] b);
      if (esc_seen) begin
        esc_seen = 1'b0;
        if (b == CodeStart) begin
          wr_idx = 0;
          sum    = '0;
        end else if (b == EscByte) begin
          put_byte(b);
        end else if (b == CodeEnd) begin
          close_frame();
        end
      end else if (b == EscByte) begin
        esc_seen = 1'b1;
      end else begin
        put_byte(b);
      end
    endfunction

    // one accepted output beat against the oldest expectation
    function void check_beat(logic [DataW-1:0] d, logic l, logic e);
      beat_t bt;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: payload_byte %0d last_of_frame %0b empty_frame %0b", d, l, e);
        errors++;
        return;
      end
      bt = pending_beats.pop_front();
      if (d !== bt.data) begin
        $error("payload_byte: expected %0d, actual %0d", bt.data, d);
        errors++;
      end
      if (l !== bt.last) begin
        $error("last_of_frame: expected %0b, actual %0b", bt.last, l);
        errors++;
      end
      if (e !== bt.empty) begin
        $error("empty_frame: expected %0b, actual %0b", bt.empty, e);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dfd_rx_if  rx_if ();
  dfd_out_if out_if ();

  frame_scoreboard sb = new();

  int src_idle_pct;
  int sink_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;

  escaped_frame_deframer_checksum #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .out_o (out_if)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HoldCycles;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_beat(out_if.payload_byte, out_if.last_of_frame, out_if.empty_frame);
    end
  end

  // offer one byte, with a random gap before it, and wait for the beat
  task automatic send_byte(input logic [DataW-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    sb.note_rx(b);
  endtask

  // random byte leaning toward the framing codes
  function automatic logic [DataW-1:0] pick_byte();
    case ($urandom_range(15))
      0, 1:    return EscByte;
      2:       return CodeStart;
      3:       return CodeEnd;
      default: return DataW'($urandom_range(255));
    endcase
  endfunction

  // a stored byte, escaped when it equals the escape byte
  function automatic void push_data(ref logic [DataW-1:0] q[$], input logic [DataW-1:0] b);
    if (b == EscByte) q.push_back(EscByte);
    q.push_back(b);
  endfunction

  // one random frame, mostly well formed, else broken or plain noise
  function automatic void build_frame(ref logic [DataW-1:0] q[$]);
    logic [DataW-1:0] pl[$];
    logic [DataW-1:0] len_b;
    logic [DataW-1:0] chk;
    logic [DataW-1:0] code;
    int               n;
    int               kind;
    int               sel;
    int               code_pos;
    kind = $urandom_range(99);
    // noise and stray end codes
    if (kind >= 92) begin
      n = $urandom_range(1, 8);
      repeat (n) q.push_back(pick_byte());
      return;
    end
    if (kind >= 87) begin
      q.push_back(EscByte);
      q.push_back(CodeEnd);
      return;
    end
    // short frame: fewer than two stored bytes
    if (kind >= 82) begin
      q.push_back(EscByte);
      q.push_back(CodeStart);
      if ($urandom_range(1)) push_data(q, pick_byte());
      q.push_back(EscByte);
      q.push_back(CodeEnd);
      return;
    end
    // payload size: mostly small, a few full or overfilled stores
    sel = $urandom_range(99);
    if (sel < 75)      n = $urandom_range(0, 8);
    else if (sel < 93) n = $urandom_range(9, 30);
    else if (sel < 97) n = MaxCount;
    else               n = $urandom_range(MaxCount + 1, MaxCount + 3);
    chk = '0;
    for (int i = 0; i < n; i++) begin
      pl.push_back(pick_byte());
      chk = chk + pl[i];
    end
    len_b = DataW'((n > MaxCount) ? MaxCount : n);
    if (kind >= 76 || kind < 60) begin
      // good frame, unknown escape codes allowed in it
    end else if (kind >= 70) begin
      len_b = len_b ^ DataW'($urandom_range(1, 255));
    end else begin
      chk = chk ^ DataW'($urandom_range(1, 255));
    end
    code_pos = (kind >= 76) ? $urandom_range(0, n) : -1;
    code = DataW'($urandom_range(1, 254));
    if (code == EscByte) code = UnknownCode;
    q.push_back(EscByte);
    q.push_back(CodeStart);
    push_data(q, len_b);
    push_data(q, chk);
    for (int i = 0; i <= n; i++) begin
      if (i == code_pos) begin
        q.push_back(EscByte);
        q.push_back(code);
      end
      if (i < n) push_data(q, pl[i]);
    end
    q.push_back(EscByte);
    q.push_back(CodeEnd);
  endfunction

  // random frames until about n_bytes have gone in
  task automatic run_phase(input int n_bytes, input int idle_pct, input int stall_pct);
    logic [DataW-1:0] q[$];
    int               sent;
    sent           = 0;
    src_idle_pct   = idle_pct;
    sink_stall_pct <= stall_pct;
    while (sent < n_bytes) begin
      q.delete();
      build_frame(q);
      foreach (q[i]) send_byte(q[i]);
      sent += q.size();
    end
  endtask

  // directed stream: empty frame, repeated end code, payload with both extremes and a
  // literal escape byte, short frame with an unknown code; the first frame writes both
  // header entries, so no later end code reads an unwritten entry
  logic [DataW-1:0] directed_q[$] = '{
    EscByte, CodeStart, 8'd0, 8'd0, EscByte, CodeEnd,
    EscByte, CodeEnd,
    EscByte, CodeStart, 8'd3, 8'd69, 8'd0, EscByte, EscByte, 8'd255, EscByte, CodeEnd,
    EscByte, CodeStart, 8'd9, EscByte, UnknownCode, EscByte, CodeEnd
  };

  // main sequence
  initial begin
    rst_ni         <= 1'b0;
    rx_if.valid    <= 1'b0;
    rx_if.rx_byte  <= '0;
    src_idle_pct   = 0;
    sink_stall_pct <= 0;
    hold_req       <= 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_byte(directed_q[i]);

    // long receiver hold-off at the start of the phase with no idling
    hold_req <= hold_req + 1;
    run_phase(PhaseBytes, 0, 0);
    run_phase(PhaseBytes, 47, 0);
    run_phase(PhaseBytes, 0, 47);
    run_phase(PhaseBytes, 11, 11);
    rx_if.valid <= 1'b0;

    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("PASS escaped_frame_deframer_checksum");
    end else begin
      $display("FAIL escaped_frame_deframer_checksum");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("FAIL escaped_frame_deframer_checksum");
    $finish;
  end

endmodule
